// File: design/amino_acid_kmer_counter_top_assert.svh
// Assertion macros for the amino-acid k-mer counter.
// Included by amino_acid_kmer_counter_top; needs no other file.
`ifndef AMINO_ACID_KMER_COUNTER_TOP_ASSERT_SVH
`define AMINO_ACID_KMER_COUNTER_TOP_ASSERT_SVH

// Same-cycle implication.
`define AAKC_ASSERT_IMP(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define AAKC_ASSERT_NXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: design/aakc_pkg.sv
// Shared types, codes and the residue lookup for the amino-acid k-mer counter.
// Depends on nothing.
`default_nettype none

package aakc_pkg;

  localparam int AlphabetSize = 20;
  localparam int CodeW        = 5;
  localparam int ResAddrW     = 5;
  localparam int ActionW      = 2;
  localparam int LetterW      = 8;
  localparam int SelW         = 3;
  localparam int AddrW        = 13;
  localparam int InDataW      = 24;
  localparam int DataW        = 32;
  localparam int StatusW      = 2;

  localparam logic [LetterW-1:0] LetterA = 8'h41;
  localparam logic [LetterW-1:0] LetterZ = 8'h5A;

  typedef enum logic [ActionW-1:0] {
    ActNext   = 2'd0,
    ActRecord = 2'd1,
    ActRead   = 2'd2
  } action_e;

  typedef enum logic [SelW-1:0] {
    SelKmer    = 3'd0,
    SelPrefix  = 3'd1,
    SelResidue = 3'd2,
    SelKTotal  = 3'd3,
    SelRTotal  = 3'd4,
    SelRecords = 3'd5,
    SelWindow  = 3'd6
  } sel_e;

  typedef enum logic [StatusW-1:0] {
    StOk      = 2'd0,
    StInvalid = 2'd1,
    StRange   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SrcConst   = 2'd0,
    SrcKmer    = 2'd1,
    SrcPrefix  = 2'd2,
    SrcResidue = 2'd3
  } src_e;

  typedef struct packed {
    logic             valid;
    logic [CodeW-1:0] code;
  } residue_t;

  function automatic residue_t residue_lookup(input logic [LetterW-1:0] letter);
    residue_t r;
    r = '{valid: 1'b1, code: '0};
    case (letter)
      "A": r.code = 5'd0;
      "B": r.code = 5'd2;
      "C": r.code = 5'd1;
      "D": r.code = 5'd2;
      "E": r.code = 5'd3;
      "F": r.code = 5'd4;
      "G": r.code = 5'd5;
      "H": r.code = 5'd6;
      "I": r.code = 5'd7;
      "K": r.code = 5'd8;
      "L": r.code = 5'd9;
      "M": r.code = 5'd10;
      "N": r.code = 5'd11;
      "P": r.code = 5'd12;
      "Q": r.code = 5'd13;
      "R": r.code = 5'd14;
      "S": r.code = 5'd15;
      "T": r.code = 5'd16;
      "U": r.code = 5'd1;
      "V": r.code = 5'd17;
      "W": r.code = 5'd18;
      "X": r.code = 5'd5;
      "Y": r.code = 5'd19;
      "Z": r.code = 5'd3;
      default: r.valid = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/amino_acid_kmer_counter_top.sv
// Top level of the amino-acid k-mer counter: window logic, three counter memories
// with read-modify-write, scalar totals and the result register. Uses aakc_pkg and
// amino_acid_kmer_counter_top_assert.svh.
`default_nettype none

// Letters, record starts and counter reads arrive as input beats; every beat gives
// exactly one result beat. After reset a clearing pass zeroes the counter
// memories, and no input beat is taken until it ends. After that the block
// takes one beat per cycle while results are taken. Each result passes through
// stage 1, which holds the memory read, then the output register, which is
// loaded as the increment is written back. A write-back is forwarded to a read
// of the same entry that is taken in the same cycle.
module amino_acid_kmer_counter_top #(
  parameter int KMER_LEN    = 3,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // letter [7:0], read_select [10:8], read_address [23:11]
  input  logic [aakc_pkg::InDataW-1:0]  s_axis_tdata_i,
  // action [1:0]
  input  logic [aakc_pkg::ActionW-1:0]  s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // read_data [31:0]
  output logic [aakc_pkg::DataW-1:0]    m_axis_tdata_o,
  // status [1:0]
  output logic [aakc_pkg::StatusW-1:0]  m_axis_tuser_o
);

  import aakc_pkg::*;

  `include "amino_acid_kmer_counter_top_assert.svh"

  localparam int KmerSpace   = AlphabetSize ** KMER_LEN;
  localparam int PrefixSpace = AlphabetSize ** (KMER_LEN - 1);
  localparam int KmerAW      = $clog2(KmerSpace);
  localparam int PrefixAW    = $clog2(PrefixSpace);
  localparam int FillW       = $clog2(KMER_LEN);

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  function automatic cnt_t sat_inc(input cnt_t v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // Input fields.
  logic [LetterW-1:0] in_letter;
  logic [SelW-1:0]    in_sel;
  logic [AddrW-1:0]   in_addr;
  action_e            in_action;
  assign in_letter = s_axis_tdata_i[7:0];
  assign in_sel    = s_axis_tdata_i[10:8];
  assign in_addr   = s_axis_tdata_i[23:11];
  assign in_action = action_e'(s_axis_tuser_i);

  // Clearing pass.
  logic              clr_busy_q;
  logic [KmerAW-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_q      <= '0;
    end else if (clr_busy_q) begin
      clr_q <= clr_q + 1'b1;
      if (clr_q == KmerAW'(KmerSpace - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Pipeline control.
  logic s1_valid_q, s1_adv, in_acc;
  logic out_valid_q;
  assign s1_adv          = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !clr_busy_q && (!s1_valid_q || s1_adv);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // Window state and scalar totals.
  logic [PrefixAW-1:0] wi_q;
  logic [FillW-1:0]    fill_q;
  logic [CodeW-1:0]    codes_q [KMER_LEN-1];
  cnt_t                ktotal_q, rtotal_q, records_q;

  residue_t            lk;
  logic                is_letter, is_record, letter_ok;
  logic [PrefixAW-1:0] wi_eff, new_wi;
  logic [FillW-1:0]    fill_eff;
  logic                full, prefix_hit;
  logic [KmerAW-1:0]   kaddr;

  assign lk        = residue_lookup(in_letter);
  assign is_record = (in_action == ActRecord);
  assign is_letter = (in_action == ActNext) || is_record;
  assign letter_ok = is_letter && lk.valid;
  assign wi_eff    = is_record ? '0 : wi_q;
  assign fill_eff  = is_record ? '0 : fill_q;
  assign full      = (fill_eff == FillW'(KMER_LEN - 1));
  assign prefix_hit = full || (fill_eff == FillW'(KMER_LEN - 2));
  assign kaddr     = KmerAW'(KmerAW'(wi_eff) * KmerAW'(AlphabetSize)) + KmerAW'(lk.code);
  assign new_wi    = full
                   ? PrefixAW'(kaddr - KmerAW'(KmerAW'(codes_q[KMER_LEN-2])
                                               * KmerAW'(PrefixSpace)))
                   : PrefixAW'(kaddr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wi_q      <= '0;
      fill_q    <= '0;
      ktotal_q  <= '0;
      rtotal_q  <= '0;
      records_q <= '0;
    end else if (in_acc) begin
      if (is_record) begin
        records_q <= sat_inc(records_q);
        wi_q      <= '0;
        fill_q    <= '0;
      end
      if (letter_ok) begin
        rtotal_q <= sat_inc(rtotal_q);
        wi_q     <= new_wi;
        fill_q   <= full ? fill_eff : fill_eff + 1'b1;
        if (full) begin
          ktotal_q <= sat_inc(ktotal_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && letter_ok) begin
      codes_q[0] <= lk.code;
      for (int i = 1; i < KMER_LEN - 1; i++) begin
        codes_q[i] <= codes_q[i-1];
      end
    end
  end

  // Memory read addresses.
  logic [KmerAW-1:0]   kmem_ra;
  logic [PrefixAW-1:0] pmem_ra;
  logic [ResAddrW-1:0] rmem_ra;
  assign kmem_ra = is_letter ? kaddr   : KmerAW'(in_addr);
  assign pmem_ra = is_letter ? new_wi  : PrefixAW'(in_addr);
  assign rmem_ra = is_letter ? lk.code : ResAddrW'(in_addr);

  // Result decode at acceptance.
  src_e              src_d;
  logic [DataW-1:0]  data_d;
  status_e           status_d;

  always_comb begin
    src_d    = SrcConst;
    data_d   = '0;
    status_d = StOk;
    if (is_letter) begin
      status_d = lk.valid ? StOk : StInvalid;
    end else if (in_action == ActRead) begin
      unique case (in_sel)
        SelKmer: begin
          if (32'(in_addr) < 32'(KmerSpace)) src_d = SrcKmer;
          else status_d = StRange;
        end
        SelPrefix: begin
          if (32'(in_addr) < 32'(PrefixSpace)) src_d = SrcPrefix;
          else status_d = StRange;
        end
        SelResidue: begin
          if (32'(in_addr) < 32'(AlphabetSize)) src_d = SrcResidue;
          else status_d = StRange;
        end
        SelKTotal:  data_d = DataW'(ktotal_q);
        SelRTotal:  data_d = DataW'(rtotal_q);
        SelRecords: data_d = DataW'(records_q);
        SelWindow:  data_d = DataW'(wi_q);
        default:    status_d = StRange;
      endcase
    end
  end

  // Stage 1 registers.
  logic                s1_we_k_q, s1_we_p_q, s1_we_r_q;
  logic [KmerAW-1:0]   s1_kaddr_q;
  logic [PrefixAW-1:0] s1_paddr_q;
  logic [ResAddrW-1:0] s1_raddr_q;
  src_e                s1_src_q;
  logic [DataW-1:0]    s1_data_q;
  status_e             s1_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_we_k_q   <= letter_ok && full;
      s1_we_p_q   <= letter_ok && prefix_hit;
      s1_we_r_q   <= letter_ok;
      s1_kaddr_q  <= kmem_ra;
      s1_paddr_q  <= pmem_ra;
      s1_raddr_q  <= rmem_ra;
      s1_src_q    <= src_d;
      s1_data_q   <= data_d;
      s1_status_q <= status_d;
    end
  end

  // Counter memories with write-back forwarding.
  cnt_t kmer_mem   [KmerSpace];
  cnt_t prefix_mem [PrefixSpace];
  cnt_t res_mem    [AlphabetSize];

  cnt_t kmer_rd_q, prefix_rd_q, res_rd_q;
  cnt_t kfwd_data_q, pfwd_data_q, rfwd_data_q;
  logic kfwd_q, pfwd_q, rfwd_q;
  cnt_t kmer_cur, prefix_cur, res_cur;
  cnt_t kmer_wd, prefix_wd, res_wd;
  logic kmer_wr, prefix_wr, res_wr;

  assign kmer_cur   = kfwd_q ? kfwd_data_q : kmer_rd_q;
  assign prefix_cur = pfwd_q ? pfwd_data_q : prefix_rd_q;
  assign res_cur    = rfwd_q ? rfwd_data_q : res_rd_q;
  assign kmer_wd    = sat_inc(kmer_cur);
  assign prefix_wd  = sat_inc(prefix_cur);
  assign res_wd     = sat_inc(res_cur);
  assign kmer_wr    = s1_valid_q && s1_adv && s1_we_k_q;
  assign prefix_wr  = s1_valid_q && s1_adv && s1_we_p_q;
  assign res_wr     = s1_valid_q && s1_adv && s1_we_r_q;

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      kmer_mem[clr_q] <= '0;
    end else if (kmer_wr) begin
      kmer_mem[s1_kaddr_q] <= kmer_wd;
    end
    if (in_acc) begin
      kmer_rd_q <= kmer_mem[kmem_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      if (clr_q < KmerAW'(PrefixSpace)) begin
        prefix_mem[PrefixAW'(clr_q)] <= '0;
      end
    end else if (prefix_wr) begin
      prefix_mem[s1_paddr_q] <= prefix_wd;
    end
    if (in_acc) begin
      prefix_rd_q <= prefix_mem[pmem_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      if (clr_q < KmerAW'(AlphabetSize)) begin
        res_mem[ResAddrW'(clr_q)] <= '0;
      end
    end else if (res_wr) begin
      res_mem[s1_raddr_q] <= res_wd;
    end
    if (in_acc) begin
      res_rd_q <= res_mem[rmem_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kfwd_q      <= kmer_wr && (s1_kaddr_q == kmem_ra);
      pfwd_q      <= prefix_wr && (s1_paddr_q == pmem_ra);
      rfwd_q      <= res_wr && (s1_raddr_q == rmem_ra);
      kfwd_data_q <= kmer_wd;
      pfwd_data_q <= prefix_wd;
      rfwd_data_q <= res_wd;
    end
  end

  // Output register.
  logic [DataW-1:0]   out_data_q;
  logic [StatusW-1:0] out_status_q;
  logic [DataW-1:0]   s1_result;

  always_comb begin
    case (s1_src_q)
      SrcKmer:    s1_result = DataW'(kmer_cur);
      SrcPrefix:  s1_result = DataW'(prefix_cur);
      SrcResidue: s1_result = DataW'(res_cur);
      default:    s1_result = s1_data_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_valid_q && s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_adv) begin
      out_data_q   <= s1_result;
      out_status_q <= s1_status_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_status_q;

  `AAKC_ASSERT_IMP(a_no_accept_in_clear, clk_i, rst_ni, clr_busy_q, !s_axis_tready_o, "input beat taken during clearing pass")
  `AAKC_ASSERT_NXT(a_s1_holds, clk_i, rst_ni, s1_valid_q && !s1_adv, s1_valid_q && $stable(s1_kaddr_q) && $stable(s1_status_q), "stage 1 item lost while stalled")
  `AAKC_ASSERT_IMP(a_fill_bound, clk_i, rst_ni, 1'b1, fill_q <= FillW'(KMER_LEN - 1), "window fill beyond k-1")

endmodule

`default_nettype wire

// File: bench/amino_acid_kmer_counter_top_tb.sv
// Self-checking testbench for amino_acid_kmer_counter_top: a directed table, then random records,
// reads and noise; each result is checked against a table value or a bench-held counter predictor.
// Depends on aakc_pkg and the top level only.
`default_nettype none

module amino_acid_kmer_counter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aakc_pkg::*;

  localparam int KmerLen     = 3;
  localparam int KmerSpace   = AlphabetSize ** KmerLen;
  localparam int PrefixSpace = AlphabetSize ** (KmerLen - 1);
  localparam int ShiftSpace  = AlphabetSize ** (KmerLen - 2);
  localparam int NumRandom   = 950;
  localparam int CycleLimit  = 400000;

  localparam logic [ActionW-1:0] ActUnused = 2'd3;
  localparam logic [SelW-1:0]    SelNone   = 3'd7;
  localparam logic [7:0]         NoCode    = 8'hFF;

  typedef struct packed {
    logic [DataW-1:0]   data;
    logic [StatusW-1:0] status;
  } outcome_t;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [LetterW-1:0] letter;
    logic [SelW-1:0]    sel;
    logic [AddrW-1:0]   addr;
    bit                 typed;
    outcome_t           want;
  } stim_row_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_valid         = 1'b0;
  logic [InDataW-1:0]  s_data          = '0;
  logic [ActionW-1:0]  s_user          = '0;
  logic                m_ready         = 1'b0;
  logic                s_axis_tready_o;
  logic                m_axis_tvalid_o;
  logic [DataW-1:0]    m_axis_tdata_o;
  logic [StatusW-1:0]  m_axis_tuser_o;

  logic [DataW-1:0]    kmer_tally    [KmerSpace];
  logic [DataW-1:0]    prefix_tally  [PrefixSpace];
  logic [DataW-1:0]    residue_tally [AlphabetSize];
  logic [DataW-1:0]    kmer_sum      = '0;
  logic [DataW-1:0]    residue_sum   = '0;
  logic [DataW-1:0]    record_sum    = '0;
  int unsigned         win_idx       = 0;
  int unsigned         win_fill      = 0;
  int unsigned         last_kmer     = 0;
  int unsigned         last_prefix   = 0;

  outcome_t            pending_outcomes [$];
  stim_row_t           directed_rows [$];
  outcome_t            oldest;
  int                  mismatches = 0;
  int                  cycles     = 0;
  bit                  quiet      = 1'b0;

  amino_acid_kmer_counter_top #(
    .KMER_LEN    (KmerLen),
    .COUNT_WIDTH (DataW)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic logic [7:0] code_of(input logic [LetterW-1:0] letter);
    case (letter)
      "A": return 8'd0;   "B": return 8'd2;   "C": return 8'd1;   "D": return 8'd2;
      "E": return 8'd3;   "F": return 8'd4;   "G": return 8'd5;   "H": return 8'd6;
      "I": return 8'd7;   "K": return 8'd8;   "L": return 8'd9;   "M": return 8'd10;
      "N": return 8'd11;  "P": return 8'd12;  "Q": return 8'd13;  "R": return 8'd14;
      "S": return 8'd15;  "T": return 8'd16;  "U": return 8'd1;   "V": return 8'd17;
      "W": return 8'd18;  "X": return 8'd5;   "Y": return 8'd19;  "Z": return 8'd3;
      default: return NoCode;
    endcase
  endfunction

  function automatic logic [DataW-1:0] sat_inc(input logic [DataW-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic logic [LetterW-1:0] pick_residue();
    logic [LetterW-1:0] l;
    do l = LetterA + LetterW'($urandom_range(0, 25)); while (code_of(l) == NoCode);
    return l;
  endfunction

  task automatic absorb_letter(input logic [LetterW-1:0] letter, output logic [StatusW-1:0] st);
    logic [7:0]  code;
    int unsigned k;
    code = code_of(letter);
    if (code == NoCode) begin
      st = StInvalid;
      return;
    end
    st = StOk;
    residue_tally[code] = sat_inc(residue_tally[code]);
    residue_sum = sat_inc(residue_sum);
    if (win_fill >= KmerLen - 1) begin
      k = win_idx * AlphabetSize + code;
      if (k < KmerSpace) begin
        kmer_tally[k] = sat_inc(kmer_tally[k]);
        last_kmer = k;
      end
      kmer_sum = sat_inc(kmer_sum);
      win_idx = (win_idx % ShiftSpace) * AlphabetSize + code;
      if (win_idx < PrefixSpace) begin
        prefix_tally[win_idx] = sat_inc(prefix_tally[win_idx]);
        last_prefix = win_idx;
      end
    end else begin
      win_idx = win_idx * AlphabetSize + code;
      win_fill++;
      if (win_fill == KmerLen - 1 && win_idx < PrefixSpace) begin
        prefix_tally[win_idx] = sat_inc(prefix_tally[win_idx]);
        last_prefix = win_idx;
      end
    end
  endtask

  task automatic predict_outcome(input logic [ActionW-1:0] action,
                                 input logic [LetterW-1:0] letter, input logic [SelW-1:0] sel,
                                 input logic [AddrW-1:0] addr, output outcome_t res);
    res = '0;
    case (action)
      ActRecord: begin
        record_sum = sat_inc(record_sum);
        win_idx = 0;
        win_fill = 0;
        absorb_letter(letter, res.status);
      end
      ActNext: begin
        absorb_letter(letter, res.status);
      end
      ActRead: begin
        case (sel)
          SelKmer: begin
            if (addr < KmerSpace) res.data = kmer_tally[addr];
            else res.status = StRange;
          end
          SelPrefix: begin
            if (addr < PrefixSpace) res.data = prefix_tally[addr];
            else res.status = StRange;
          end
          SelResidue: begin
            if (addr < AlphabetSize) res.data = residue_tally[addr];
            else res.status = StRange;
          end
          SelKTotal:  res.data = kmer_sum;
          SelRTotal:  res.data = residue_sum;
          SelRecords: res.data = record_sum;
          SelWindow:  res.data = DataW'(win_idx);
          default:    res.status = StRange;
        endcase
      end
      default: ;
    endcase
  endtask

  task automatic send_beat(input logic [ActionW-1:0] action, input logic [LetterW-1:0] letter,
                           input logic [SelW-1:0] sel, input logic [AddrW-1:0] addr,
                           input bit typed, input outcome_t want);
    outcome_t pred;
    if (!quiet) begin
      while ($urandom_range(0, 99) < 6) begin
        s_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_valid <= 1'b1;
    s_data  <= {addr, sel, letter};
    s_user  <= action;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_outcome(action, letter, sel, addr, pred);
    pending_outcomes.push_back(typed ? want : pred);
  endtask

  task automatic send_random_read();
    logic [SelW-1:0]  sel;
    logic [AddrW-1:0] addr;
    sel = SelW'($urandom_range(0, 7));
    case (sel)
      SelKmer:    addr = $urandom_range(0, 1) ? AddrW'(last_kmer) : AddrW'($urandom_range(0, 8191));
      SelPrefix:  addr = $urandom_range(0, 1) ? AddrW'(last_prefix) : AddrW'($urandom_range(0, 511));
      SelResidue: addr = AddrW'($urandom_range(0, 31));
      default:    addr = AddrW'($urandom_range(0, 8191));
    endcase
    send_beat(ActRead, LetterW'($urandom_range(0, 255)), sel, addr, 1'b0, '0);
  endtask

  task automatic add_row(input logic [ActionW-1:0] action, input logic [LetterW-1:0] letter,
                         input logic [SelW-1:0] sel, input logic [AddrW-1:0] addr,
                         input bit typed, input logic [DataW-1:0] data,
                         input logic [StatusW-1:0] status);
    directed_rows.push_back('{action, letter, sel, addr, typed, '{data, status}});
  endtask

  task automatic note_mismatch(input string what, input outcome_t want);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected data %0d status %0d, got data %0d status %0d",
               what, want.data, want.status, m_axis_tdata_o, m_axis_tuser_o);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      if (pending_outcomes.size() == 0) begin
        note_mismatch("Result beat with nothing expected", '0);
      end else begin
        oldest = pending_outcomes.pop_front();
        if (m_axis_tdata_o !== oldest.data || m_axis_tuser_o !== oldest.status) begin
          note_mismatch("Result mismatch", oldest);
        end
      end
    end
    m_ready <= quiet || ($urandom_range(0, 99) >= 6);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("amino_acid_kmer_counter_top verification failed");
      $finish;
    end
  end

  initial begin
    int        sent;
    int        body_len;
    bit        drained;
    stim_row_t r;
    sent = 0;
    drained = 1'b0;
    foreach (kmer_tally[i]) kmer_tally[i] = '0;
    foreach (prefix_tally[i]) prefix_tally[i] = '0;
    foreach (residue_tally[i]) residue_tally[i] = '0;

    add_row(ActRead,   "A",   SelKmer,    13'd0,    1'b1, '0, StOk);
    add_row(ActRead,   "A",   SelKmer,    13'd7999, 1'b1, '0, StOk);
    add_row(ActRead,   "A",   SelKmer,    13'd8000, 1'b1, '0, StRange);
    add_row(ActRead,   8'hFF, SelKmer,    13'd8191, 1'b1, '0, StRange);
    add_row(ActRead,   "A",   SelPrefix,  13'd399,  1'b1, '0, StOk);
    add_row(ActRead,   "A",   SelPrefix,  13'd400,  1'b1, '0, StRange);
    add_row(ActRead,   "A",   SelResidue, 13'd19,   1'b1, '0, StOk);
    add_row(ActRead,   "A",   SelResidue, 13'd20,   1'b1, '0, StRange);
    add_row(ActRead,   "A",   SelNone,    13'd0,    1'b1, '0, StRange);
    add_row(ActUnused, "A",   SelKmer,    13'd0,    1'b1, '0, StOk);
    add_row(ActNext,   "A",   SelKmer,    13'd0,    1'b0, '0, StOk);
    add_row(ActNext,   "Z",   SelKmer,    13'd0,    1'b0, '0, StOk);
    add_row(ActNext,   "Y",   SelKmer,    13'd0,    1'b0, '0, StOk);
    add_row(ActNext,   8'h00, SelKmer,    13'd0,    1'b1, '0, StInvalid);
    add_row(ActNext,   8'hFF, SelWindow,  13'd8191, 1'b1, '0, StInvalid);
    add_row(ActNext,   "J",   SelKmer,    13'd0,    1'b1, '0, StInvalid);
    add_row(ActRecord, "O",   SelKmer,    13'd0,    1'b1, '0, StInvalid);
    add_row(ActNext,   "[",   SelKmer,    13'd0,    1'b1, '0, StInvalid);
    add_row(ActRecord, "M",   SelKmer,    13'd0,    1'b0, '0, StOk);
    add_row(ActNext,   "W",   SelKmer,    13'd0,    1'b0, '0, StOk);
    add_row(ActNext,   "X",   SelKmer,    13'd0,    1'b0, '0, StOk);
    add_row(ActRead,   "A",   SelWindow,  13'd8191, 1'b0, '0, StOk);
    add_row(ActRead,   "A",   SelKTotal,  13'd5,    1'b0, '0, StOk);
    add_row(ActRead,   "A",   SelRTotal,  13'd0,    1'b0, '0, StOk);
    add_row(ActRead,   "A",   SelRecords, 13'd0,    1'b0, '0, StOk);

    wait (rst_ni);
    @(posedge clk_i);
    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      send_beat(r.action, r.letter, r.sel, r.addr, r.typed, r.want);
    end

    while (sent < NumRandom) begin
      quiet = (sent >= 300 && sent < 450);
      if (!drained && sent >= 600) begin
        drained = 1'b1;
        s_valid <= 1'b0;
        do @(posedge clk_i); while (pending_outcomes.size() != 0);
      end
      if ($urandom_range(0, 99) < 85) begin
        send_beat(ActRecord, pick_residue(), SelW'($urandom_range(0, 7)),
                  AddrW'($urandom_range(0, 8191)), 1'b0, '0);
        sent++;
        body_len = $urandom_range(2, 30);
        repeat (body_len) begin
          if ($urandom_range(0, 99) < 15) send_random_read();
          else if ($urandom_range(0, 99) < 3)
            send_beat(ActNext, LetterW'($urandom_range(0, 255)), SelKmer, '0, 1'b0, '0);
          else send_beat(ActNext, pick_residue(), SelKmer, '0, 1'b0, '0);
          sent++;
        end
      end else begin
        send_beat(ActionW'($urandom_range(0, 3)), LetterW'($urandom_range(0, 255)),
                  SelW'($urandom_range(0, 7)), AddrW'($urandom_range(0, 8191)), 1'b0, '0);
        sent++;
      end
    end
    quiet = 1'b0;
    s_valid <= 1'b0;

    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("amino_acid_kmer_counter_top verification clean");
    end else begin
      $display("amino_acid_kmer_counter_top verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
